### design/sete_pkg.sv
// ----------------------------------------------------------------------------
// sete_pkg
// Shared types, constants and helpers for the sprite entry tile expander.
// ----------------------------------------------------------------------------
package sete_pkg;

  // mirror axis for sprite positions
  localparam logic [9:0] MIRROR_AXIS = 10'd240;

  // one column of a sprite, handed from the front to the back
  typedef struct packed {
    logic [10:0] base;         // tile code with the low row bits cleared
    logic [9:0]  x;            // screen x of the column
    logic [9:0]  y;            // screen y of the top tile
    logic        flip_x;
    logic        flip_y;
    logic [3:0]  color;
    logic [1:0]  height_code;  // log2 of tiles per column
    logic        screen;       // screen flip held for the sprite
  } col_desc_t;

  // 2**code - 1 for a size code of 1, 2, 4 or 8 tiles
  function automatic logic [2:0] size_mask(input logic [1:0] code);
    logic [2:0] m;
    case (code)
      2'd0:    m = 3'd0;
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd3;
      default: m = 3'd7;
    endcase
    return m;
  endfunction

endpackage

### design/sprite_entry_tile_expander_unit.sv
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander_unit
// Expands sprite list entries into per-tile draw records.
// ----------------------------------------------------------------------------
// the first tile of an entry passes the queue, the descriptor register and the
// output register; the back end emits one tile per cycle while the output does
//   not stall, so an entry of height h (1 to 8) gives h tiles; drops push nothing
// the two-entry queue lets the front take entries while the back is busy
// reset: synchronous active-low rst_n clears sprite state, queue and output valid
module sprite_entry_tile_expander_unit
  import sete_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_attr_word,
  input  logic [15:0] in_code_word,
  input  logic [15:0] in_pos_word,
  input  logic        in_odd_frame,
  input  logic        in_list_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_tile_code,
  output logic signed [9:0] out_x_pos,
  output logic signed [9:0] out_y_pos,
  output logic        out_mirror_x,
  output logic        out_mirror_y,
  output logic [3:0]  out_palette_bank,
  output logic        out_last_tile
);

  logic      push_valid;
  col_desc_t push_desc;
  logic      q_full;
  logic      q_valid;
  col_desc_t q_desc;
  logic      pop;
  logic [9:0] x_pos;
  logic [9:0] y_pos;

  // entry classification
  sete_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_attr_word  (in_attr_word),
    .in_code_word  (in_code_word),
    .in_pos_word   (in_pos_word),
    .in_odd_frame  (in_odd_frame),
    .in_list_start (in_list_start),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_desc     (push_desc)
  );

  // column queue
  sete_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_desc     (q_desc),
    .pop        (pop)
  );

  // tile walker
  sete_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_desc           (q_desc),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tile_code    (out_tile_code),
    .out_x_pos        (x_pos),
    .out_y_pos        (y_pos),
    .out_mirror_x     (out_mirror_x),
    .out_mirror_y     (out_mirror_y),
    .out_palette_bank (out_palette_bank),
    .out_last_tile    (out_last_tile)
  );

  assign out_x_pos = signed'(x_pos);
  assign out_y_pos = signed'(y_pos);

endmodule

### design/sete_front.sv
// ----------------------------------------------------------------------------
// sete_front
// Takes list entries, sorts heads from continuations, drops disabled or
// flashing heads and builds one column descriptor per kept entry.
// ----------------------------------------------------------------------------
module sete_front
  import sete_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_attr_word,
  input  logic [15:0] in_code_word,
  input  logic [15:0] in_pos_word,
  input  logic        in_odd_frame,
  input  logic        in_list_start,
  input  logic        q_full,
  output logic        push_valid,
  output col_desc_t   push_desc
);

  logic       flip_screen_r;
  logic [2:0] columns_left_r, columns_left_nxt;
  logic [2:0] column_index_r, column_index_nxt;
  logic [1:0] height_code_r, height_code_nxt;
  logic [9:0] anchor_x_r, anchor_x_nxt;
  logic [9:0] anchor_y_r, anchor_y_nxt;
  logic       hold_flip_x_r, hold_flip_x_nxt;
  logic       hold_flip_y_r, hold_flip_y_nxt;
  logic [3:0] hold_color_r, hold_color_nxt;
  logic       hold_screen_r, hold_screen_nxt;

  logic       accept;
  logic       is_cont;
  logic       drop;
  logic [9:0] sx, sy;
  logic [9:0] head_x, head_y;
  logic [9:0] col_off;
  logic [9:0] cont_x;
  logic [2:0] head_hmask;
  logic [2:0] cont_hmask;

  // screen flip register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_screen_r <= 1'b0;
    end else if (cfg_wr_en) begin
      flip_screen_r <= cfg_wr_data;
    end
  end

  // classify the entry
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_cont  = (columns_left_r != 3'd0) && !in_list_start;
  assign drop     = !in_attr_word[15] || (in_pos_word[11] && !in_odd_frame);

  // head anchor: mirrored about the axis, screen flip mirrors it back
  assign sx     = {in_pos_word[8], in_pos_word[8:0]};
  assign sy     = {in_attr_word[8], in_attr_word[8:0]};
  assign head_x = flip_screen_r ? sx : MIRROR_AXIS - sx;
  assign head_y = flip_screen_r ? sy : MIRROR_AXIS - sy;

  // continuation column position, sixteen pixels per column
  assign col_off = {3'b000, column_index_r, 4'b0000};
  assign cont_x  = hold_screen_r ? anchor_x_r + col_off : anchor_x_r - col_off;

  assign head_hmask = size_mask(in_attr_word[12:11]);
  assign cont_hmask = size_mask(height_code_r);

  // descriptor for the queue
  always_comb begin
    push_valid = accept && (is_cont || !drop);
    if (is_cont) begin
      push_desc.base        = in_code_word[10:0] & ~{8'b0, cont_hmask};
      push_desc.x           = cont_x;
      push_desc.y           = anchor_y_r;
      push_desc.flip_x      = hold_flip_x_r;
      push_desc.flip_y      = hold_flip_y_r;
      push_desc.color       = hold_color_r;
      push_desc.height_code = height_code_r;
      push_desc.screen      = hold_screen_r;
    end else begin
      push_desc.base        = in_code_word[10:0] & ~{8'b0, head_hmask};
      push_desc.x           = head_x;
      push_desc.y           = head_y;
      push_desc.flip_x      = in_attr_word[13] ^ flip_screen_r;
      push_desc.flip_y      = in_attr_word[14] ^ flip_screen_r;
      push_desc.color       = in_pos_word[15:12];
      push_desc.height_code = in_attr_word[12:11];
      push_desc.screen      = flip_screen_r;
    end
  end

  // sprite state update
  always_comb begin
    columns_left_nxt = columns_left_r;
    column_index_nxt = column_index_r;
    height_code_nxt  = height_code_r;
    anchor_x_nxt     = anchor_x_r;
    anchor_y_nxt     = anchor_y_r;
    hold_flip_x_nxt  = hold_flip_x_r;
    hold_flip_y_nxt  = hold_flip_y_r;
    hold_color_nxt   = hold_color_r;
    hold_screen_nxt  = hold_screen_r;
    if (accept) begin
      if (is_cont) begin
        columns_left_nxt = columns_left_r - 3'd1;
        column_index_nxt = column_index_r + 3'd1;
      end else if (!drop) begin
        columns_left_nxt = size_mask(in_attr_word[10:9]);
        column_index_nxt = 3'd1;
        height_code_nxt  = in_attr_word[12:11];
        anchor_x_nxt     = head_x;
        anchor_y_nxt     = head_y;
        hold_flip_x_nxt  = push_desc.flip_x;
        hold_flip_y_nxt  = push_desc.flip_y;
        hold_color_nxt   = in_pos_word[15:12];
        hold_screen_nxt  = flip_screen_r;
      end else begin
        // dropped head, list start discards pending columns
        columns_left_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_left_r <= 3'd0;
      column_index_r <= 3'd0;
      height_code_r  <= 2'd0;
      anchor_x_r     <= 10'd0;
      anchor_y_r     <= 10'd0;
      hold_flip_x_r  <= 1'b0;
      hold_flip_y_r  <= 1'b0;
      hold_color_r   <= 4'd0;
      hold_screen_r  <= 1'b0;
    end else begin
      columns_left_r <= columns_left_nxt;
      column_index_r <= column_index_nxt;
      height_code_r  <= height_code_nxt;
      anchor_x_r     <= anchor_x_nxt;
      anchor_y_r     <= anchor_y_nxt;
      hold_flip_x_r  <= hold_flip_x_nxt;
      hold_flip_y_r  <= hold_flip_y_nxt;
      hold_color_r   <= hold_color_nxt;
      hold_screen_r  <= hold_screen_nxt;
    end
  end

endmodule

### design/sete_queue.sv
// ----------------------------------------------------------------------------
// sete_queue
// Two-entry column descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module sete_queue
  import sete_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  col_desc_t push_desc,
  output logic      q_full,
  output logic      q_valid,
  output col_desc_t q_desc,
  input  logic      pop
);

  col_desc_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_desc  = mem_r[rd_ptr_r];

  // storage write
  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = push_valid ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push_valid && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  // never more than two entries held
  assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("queue count out of range");
  // front never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) push_valid |-> !q_full)
    else $error("push into full queue");
`endif

endmodule

### design/sete_back.sv
// ----------------------------------------------------------------------------
// sete_back
// Walks one column descriptor at a time, one tile per cycle while the output
// does not stall, into the output register.
// ----------------------------------------------------------------------------
module sete_back
  import sete_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  col_desc_t   q_desc,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_tile_code,
  output logic [9:0]  out_x_pos,
  output logic [9:0]  out_y_pos,
  output logic        out_mirror_x,
  output logic        out_mirror_y,
  output logic [3:0]  out_palette_bank,
  output logic        out_last_tile
);

  col_desc_t  desc_r;
  logic       busy_r, busy_nxt;
  logic [2:0] row_r, row_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [10:0] tile_code_r;
  logic [9:0]  x_pos_r;
  logic [9:0]  y_pos_r;
  logic        mirror_x_r;
  logic        mirror_y_r;
  logic [3:0]  palette_bank_r;
  logic        last_tile_r;

  logic       adv;
  logic [2:0] hmask;
  logic       last_row;
  logic [9:0] row_off;
  logic [9:0] tile_y;
  logic [2:0] code_row;
  logic [10:0] tile_code;

  // tile of the current row
  assign hmask     = size_mask(desc_r.height_code);
  assign last_row  = (row_r == hmask);
  assign row_off   = {3'b000, row_r, 4'b0000};
  assign tile_y    = desc_r.screen ? desc_r.y + row_off : desc_r.y - row_off;
  assign code_row  = desc_r.flip_y ? row_r : hmask - row_r;
  assign tile_code = desc_r.base + {8'b0, code_row};

  // advance when a tile is ready and the output register frees up
  assign adv = busy_r && (!out_valid_r || !out_stall);
  assign pop = q_valid && (!busy_r || (adv && last_row));

  always_comb begin
    busy_nxt      = busy_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    if (pop) begin
      busy_nxt = 1'b1;
      row_nxt  = 3'd0;
    end else if (adv && last_row) begin
      busy_nxt = 1'b0;
      row_nxt  = 3'd0;
    end else if (adv) begin
      row_nxt = row_r + 3'd1;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      row_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // descriptor and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      desc_r <= q_desc;
    end
    if (adv) begin
      tile_code_r    <= tile_code;
      x_pos_r        <= desc_r.x;
      y_pos_r        <= tile_y;
      mirror_x_r     <= desc_r.flip_x;
      mirror_y_r     <= desc_r.flip_y;
      palette_bank_r <= desc_r.color;
      last_tile_r    <= last_row;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tile_code    = tile_code_r;
  assign out_x_pos        = x_pos_r;
  assign out_y_pos        = y_pos_r;
  assign out_mirror_x     = mirror_x_r;
  assign out_mirror_y     = mirror_y_r;
  assign out_palette_bank = palette_bank_r;
  assign out_last_tile    = last_tile_r;

`ifndef SYNTHESIS
  // idle walker always parks at the top row
  assert property (@(posedge clk) disable iff (!rst_n) !busy_r |-> row_r == 3'd0)
    else $error("row counter not parked while idle");
  // a new output transfer only comes from a busy walker
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid_r) |-> $past(busy_r))
    else $error("output raised without a column in progress");
`endif

endmodule
